@@ design/sps_pkg.sv @@
`timescale 1ns / 1ps

package sps_pkg;

  // Full motor turn in steps; position and target never exceed it.
  localparam int STEPS_PER_TURN = 4096;
  localparam int POS_W = $clog2(STEPS_PER_TURN + 1);

  localparam int FUNC_W  = 3;
  localparam int ANGLE_W = 9;
  localparam int COIL_W  = 4;
  localparam int PHASE_W = 3;

  localparam logic [ANGLE_W-1:0] ANGLE_MAX = ANGLE_W'(360);

  // Command codes
  localparam logic [FUNC_W-1:0] FUNC_TICK        = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_TARGET  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_CURRENT = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MOVE_LEFT   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_MOVE_RIGHT  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_STOP        = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_HOME        = 3'd6;

  // degrees -> steps: deg * STEPS / 360 as a multiply by a rounded-up reciprocal.
  // The rounding error stays below the smallest fractional gap, so it is exact.
  localparam int DEG_SHIFT = 20;
  localparam logic [63:0] DEG_MUL_FULL =
    ((64'(STEPS_PER_TURN) << DEG_SHIFT) + 64'd359) / 64'd360;
  localparam int DEG_MUL_W = $clog2(DEG_MUL_FULL + 64'd1);
  localparam logic [DEG_MUL_W-1:0] DEG_MUL = DEG_MUL_W'(DEG_MUL_FULL);
  localparam int DEG_PROD_W = ANGLE_W + DEG_MUL_W;

  // steps -> degrees: steps * 360 / STEPS, same technique.
  localparam int POS_SHIFT = 27;
  localparam logic [63:0] POS_MUL_FULL =
    ((64'd360 << POS_SHIFT) + 64'(STEPS_PER_TURN) - 64'd1) / 64'(STEPS_PER_TURN);
  localparam int POS_MUL_W = $clog2(POS_MUL_FULL + 64'd1);
  localparam logic [POS_MUL_W-1:0] POS_MUL = POS_MUL_W'(POS_MUL_FULL);
  localparam int POS_PROD_W = POS_W + POS_MUL_W;

  localparam logic [POS_W-1:0] HOME_STEPS =
    POS_W'((64'd90 * 64'(STEPS_PER_TURN)) / 64'd360);

  // Register map
  localparam int PADDR_W = 3;
  localparam logic REG_STEP_MODE = 1'b0;

  typedef struct packed {
    logic [COIL_W-1:0] coils;
    logic              busy;
    logic [POS_W-1:0]  pos;
  } sps_status_t;

  // Coil pattern: half-step A,AB,B,BC,C,CD,D,DA; full-step AB,BC,CD,DA.
  function automatic logic [COIL_W-1:0] coil_pattern(input logic half,
                                                     input logic [PHASE_W-1:0] idx);
    logic [COIL_W-1:0] pat;
    if (half) begin
      case (idx)
        3'd0:    pat = 4'h1;
        3'd1:    pat = 4'h3;
        3'd2:    pat = 4'h2;
        3'd3:    pat = 4'h6;
        3'd4:    pat = 4'h4;
        3'd5:    pat = 4'hC;
        3'd6:    pat = 4'h8;
        default: pat = 4'h9;
      endcase
    end else begin
      case (idx[1:0])
        2'd0:    pat = 4'h3;
        2'd1:    pat = 4'h6;
        2'd2:    pat = 4'hC;
        default: pat = 4'h9;
      endcase
    end
    return pat;
  endfunction

endpackage

@@ design/sps_cmd_if.sv @@
`timescale 1ns / 1ps

interface sps_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [sps_pkg::FUNC_W-1:0]     func;
  logic [sps_pkg::ANGLE_W-1:0]    angle_value;

  modport source (output valid, output func, output angle_value, input ready);
  modport sink   (input valid, input func, input angle_value, output ready);
endinterface

@@ design/sps_res_if.sv @@
`timescale 1ns / 1ps

interface sps_res_if;
  logic                           valid;
  logic                           ready;
  logic [sps_pkg::COIL_W-1:0]     coils;
  logic                           busy_res;
  logic [sps_pkg::ANGLE_W-1:0]    position_degrees;

  modport source (output valid, output coils, output busy_res, output position_degrees,
                  input ready);
  modport sink   (input valid, input coils, input busy_res, input position_degrees,
                  output ready);
endinterface

@@ design/sps_cfg.sv @@
`timescale 1ns / 1ps

module sps_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output logic                         step_mode
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_mode <= 1'b1;
    end else if (wr_en && paddr[2] == sps_pkg::REG_STEP_MODE) begin
      step_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == sps_pkg::REG_STEP_MODE) begin
      prdata = {31'b0, step_mode};
    end
  end

endmodule

@@ design/sps_core.sv @@
`timescale 1ns / 1ps

module sps_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_mode,
  sps_cmd_if.sink               cmd,
  output logic                  mid_valid,
  input  logic                  mid_ready,
  output sps_pkg::sps_status_t  mid_status
);

  // input register
  logic                            in_valid;
  logic [sps_pkg::FUNC_W-1:0]      in_func;
  logic [sps_pkg::ANGLE_W-1:0]     in_angle;

  // motor state
  logic [sps_pkg::POS_W-1:0]       position_steps, position_steps_next;
  logic [sps_pkg::POS_W-1:0]       target_steps, target_steps_next;
  logic [sps_pkg::PHASE_W-1:0]     phase_index, phase_index_next;
  logic                            direction_left, direction_left_next;
  logic                            busy_flag, busy_flag_next;
  logic                            running_flag, running_flag_next;
  logic [sps_pkg::COIL_W-1:0]      coil_state, coil_state_next;

  logic                            mid_en, in_en, fire;
  logic [sps_pkg::DEG_PROD_W-1:0]  angle_prod;
  logic [sps_pkg::POS_W-1:0]       angle_steps;
  logic                            angle_ok;
  logic [sps_pkg::PHASE_W-1:0]     phase_inc, phase_step, seq_idx;

  assign mid_en    = !mid_valid || mid_ready;
  assign in_en     = !in_valid || mid_en;
  assign cmd.ready = in_en;
  assign fire      = in_valid && mid_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_en) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_en && cmd.valid) begin
      in_func  <= cmd.func;
      in_angle <= cmd.angle_value;
    end
  end

  assign angle_prod  = sps_pkg::DEG_PROD_W'(in_angle) * sps_pkg::DEG_PROD_W'(sps_pkg::DEG_MUL);
  assign angle_steps = angle_prod[sps_pkg::DEG_SHIFT +: sps_pkg::POS_W];
  assign angle_ok    = in_angle <= sps_pkg::ANGLE_MAX;

  // Phase wraps modulo 8 in half-step, modulo 4 in full-step
  assign phase_inc  = phase_index + 3'd1;
  assign phase_step = step_mode ? phase_inc : {1'b0, phase_inc[1:0]};
  assign seq_idx    = direction_left ? (phase_step - 3'd1) : (3'd0 - phase_step);

  always_comb begin
    position_steps_next = position_steps;
    target_steps_next   = target_steps;
    phase_index_next    = phase_index;
    direction_left_next = direction_left;
    busy_flag_next      = busy_flag;
    running_flag_next   = running_flag;
    coil_state_next     = coil_state;
    case (in_func)
      sps_pkg::FUNC_TICK: begin
        if (running_flag) begin
          if (position_steps < target_steps) begin
            position_steps_next = position_steps + 1'b1;
            phase_index_next    = phase_step;
            coil_state_next     = sps_pkg::coil_pattern(step_mode, seq_idx);
          end else begin
            busy_flag_next    = 1'b0;
            running_flag_next = 1'b0;
            coil_state_next   = '0;
          end
        end
      end
      sps_pkg::FUNC_SET_TARGET: begin
        if (angle_ok) begin
          target_steps_next = angle_steps;
          busy_flag_next    = 1'b1;
          running_flag_next = 1'b1;
        end
      end
      sps_pkg::FUNC_SET_CURRENT: begin
        if (angle_ok) begin
          position_steps_next = angle_steps;
        end
      end
      sps_pkg::FUNC_MOVE_LEFT, sps_pkg::FUNC_MOVE_RIGHT: begin
        direction_left_next = (in_func == sps_pkg::FUNC_MOVE_LEFT);
        position_steps_next = '0;
        if (angle_ok) begin
          target_steps_next = angle_steps;
          busy_flag_next    = 1'b1;
          running_flag_next = 1'b1;
        end
      end
      sps_pkg::FUNC_STOP: begin
        // Zero target with running set: the next tick powers the coils down
        target_steps_next   = '0;
        position_steps_next = '0;
        busy_flag_next      = 1'b1;
        running_flag_next   = 1'b1;
      end
      sps_pkg::FUNC_HOME: begin
        direction_left_next = 1'b1;
        position_steps_next = '0;
        target_steps_next   = sps_pkg::HOME_STEPS;
        busy_flag_next      = 1'b1;
        running_flag_next   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_steps <= '0;
      target_steps   <= '0;
      phase_index    <= '0;
      direction_left <= 1'b0;
      busy_flag      <= 1'b0;
      running_flag   <= 1'b0;
      coil_state     <= '0;
    end else if (fire) begin
      position_steps <= position_steps_next;
      target_steps   <= target_steps_next;
      phase_index    <= phase_index_next;
      direction_left <= direction_left_next;
      busy_flag      <= busy_flag_next;
      running_flag   <= running_flag_next;
      coil_state     <= coil_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_en) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      mid_status.coils <= coil_state_next;
      mid_status.busy  <= busy_flag_next;
      mid_status.pos   <= position_steps_next;
    end
  end

`ifndef SYNTHESIS
  a_busy_tracks_running: assert property (@(posedge clk) disable iff (rst)
    busy_flag == running_flag)
    else $error("busy and running flags disagree");

  a_idle_coils_off: assert property (@(posedge clk) disable iff (rst)
    !busy_flag |-> coil_state == '0)
    else $error("coils energized while not busy");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    position_steps <= sps_pkg::POS_W'(sps_pkg::STEPS_PER_TURN) &&
    target_steps <= sps_pkg::POS_W'(sps_pkg::STEPS_PER_TURN))
    else $error("position or target beyond one turn");

  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    fire && in_func == sps_pkg::FUNC_TICK && running_flag &&
    position_steps < target_steps |=> position_steps == $past(position_steps) + 1'b1)
    else $error("running tick did not advance position");
`endif

endmodule

@@ design/sps_conv.sv @@
`timescale 1ns / 1ps

module sps_conv (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  mid_valid,
  output logic                  mid_ready,
  input  sps_pkg::sps_status_t  mid_status,
  sps_res_if.source             res
);

  logic                            out_en;
  logic [sps_pkg::POS_PROD_W-1:0]  pos_prod;

  assign out_en    = !res.valid || res.ready;
  assign mid_ready = out_en;

  assign pos_prod = sps_pkg::POS_PROD_W'(mid_status.pos) *
                    sps_pkg::POS_PROD_W'(sps_pkg::POS_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_en) begin
      res.valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && mid_valid) begin
      res.coils            <= mid_status.coils;
      res.busy_res         <= mid_status.busy;
      res.position_degrees <= pos_prod[sps_pkg::POS_SHIFT +: sps_pkg::ANGLE_W];
    end
  end

endmodule

@@ design/stepper_phase_sequencer.sv @@
`timescale 1ns / 1ps

// Unipolar stepper phase sequencer.
// cmd channel: one transaction per command (func, angle_value). Ticks advance
// a running move by one step; other codes load target/current position,
// start left/right moves, stop or go home.
// res channel: exactly one transaction per command, in order, carrying the
// coil drive, busy flag and position in degrees after that command.
// Configuration: APB register 0 (byte address 0), bit 0 = step_mode,
// 0 full-step, 1 half-step. Write only while no command is in flight.
// Pipeline: the accepting edge loads the input register, then the state-update
// stage registers the new status, then the degree-conversion output register
// drives res.
// Throughput: one command per cycle while res.ready is high; the state update of
// one command is registered when it fires, so the next command sees it immediately.
// Reset: clears all pipeline valids and motor state (coils off, position
// and target zero, not busy); step_mode returns to half-step.
// Stall: when res.ready is low the three stages fill and cmd.ready drops;
// no transaction is lost or repeated.
module stepper_phase_sequencer (
  input  logic                         clk,
  input  logic                         rst,
  sps_cmd_if.sink                      cmd,
  sps_res_if.source                    res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sps_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic                 step_mode;
  logic                 mid_valid;
  logic                 mid_ready;
  sps_pkg::sps_status_t mid_status;

  sps_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .step_mode (step_mode)
  );

  sps_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step_mode  (step_mode),
    .cmd        (cmd),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid_status (mid_status)
  );

  sps_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .mid_valid  (mid_valid),
    .mid_ready  (mid_ready),
    .mid_status (mid_status),
    .res        (res)
  );

endmodule

@@ tb/sps_status_checker.sv @@
`timescale 1ns / 1ps

module sps_status_checker
  import sps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  sps_cmd_if                 cmd,
  sps_res_if                 res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output int                 mismatches,
  output int                 outstanding,
  output int                 checked
);

  localparam int DEG_PER_TURN = 360;
  localparam logic [ANGLE_W-1:0] HOME_DEG = ANGLE_W'(90);

  // Coil patterns packed with entry 0 in the low nibble.
  localparam logic [15:0] FULL_SEQ = 16'h9C63;
  localparam logic [31:0] HALF_SEQ = 32'h98C46231;

  typedef struct packed {
    logic [COIL_W-1:0]  coils;
    logic               busy;
    logic [ANGLE_W-1:0] degrees;
  } status_t;

  status_t status_q[$];

  logic               half_mode;
  logic [POS_W-1:0]   position;
  logic [POS_W-1:0]   target;
  logic [PHASE_W-1:0] phase;
  logic               dir_left;
  logic               busy;
  logic               running;
  logic [COIL_W-1:0]  coil_drive;

  function automatic logic [POS_W-1:0] to_steps(input logic [ANGLE_W-1:0] deg);
    return POS_W'(int'(deg) * STEPS_PER_TURN / DEG_PER_TURN);
  endfunction

  function automatic void load_target(input logic [ANGLE_W-1:0] deg);
    if (deg <= ANGLE_MAX) begin
      target = to_steps(deg);
      busy = 1'b1;
      running = 1'b1;
    end
  endfunction

  function automatic void load_current(input logic [ANGLE_W-1:0] deg);
    if (deg <= ANGLE_MAX)
      position = to_steps(deg);
  endfunction

  function automatic status_t apply_command(input logic [FUNC_W-1:0] f,
                                            input logic [ANGLE_W-1:0] deg);
    status_t s;
    int n;
    int idx;
    case (f)
      FUNC_TICK: begin
        if (running) begin
          if (position < target) begin
            n = half_mode ? 8 : 4;
            position = position + 1'b1;
            phase = PHASE_W'((int'(phase) + 1) % n);
            idx = dir_left ? (int'(phase) + n - 1) % n : (n - int'(phase)) % n;
            coil_drive = half_mode ? HALF_SEQ[idx*4 +: 4] : FULL_SEQ[idx*4 +: 4];
          end else begin
            busy = 1'b0;
            running = 1'b0;
            coil_drive = '0;
          end
        end
      end
      FUNC_SET_TARGET: load_target(deg);
      FUNC_SET_CURRENT: load_current(deg);
      FUNC_MOVE_LEFT, FUNC_MOVE_RIGHT: begin
        // direction and zeroed position apply even when the angle is rejected
        dir_left = (f == FUNC_MOVE_LEFT);
        load_current('0);
        load_target(deg);
      end
      FUNC_STOP: begin
        load_target('0);
        load_current('0);
      end
      FUNC_HOME: begin
        dir_left = 1'b1;
        load_current('0);
        load_target(HOME_DEG);
      end
      default: ;
    endcase
    s.coils = coil_drive;
    s.busy = busy;
    s.degrees = ANGLE_W'(int'(position) * DEG_PER_TURN / STEPS_PER_TURN);
    return s;
  endfunction

  always @(posedge clk) begin : monitor
    status_t want;
    status_t got;
    if (rst) begin
      half_mode = 1'b1;
      position = '0;
      target = '0;
      phase = '0;
      dir_left = 1'b0;
      busy = 1'b0;
      running = 1'b0;
      coil_drive = '0;
      status_q.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (res.valid && res.ready) begin
        got.coils = res.coils;
        got.busy = res.busy_res;
        got.degrees = res.position_degrees;
        if (status_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result coils %h busy %b deg %0d",
                     $realtime, got.coils, got.busy, got.degrees);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          checked++;
          if (got.coils !== want.coils || got.busy !== want.busy ||
              got.degrees !== want.degrees) begin
            if (mismatches < 10)
              $display("%0t: mismatch expected coils %h busy %b deg %0d, got coils %h busy %b deg %0d",
                       $realtime, want.coils, want.busy, want.degrees,
                       got.coils, got.busy, got.degrees);
            mismatches++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr[PADDR_W-1:2] == REG_STEP_MODE)
        half_mode = pwdata[0];
      if (cmd.valid && cmd.ready)
        status_q.push_back(apply_command(cmd.func, cmd.angle_value));
    end
    outstanding = status_q.size();
  end

endmodule

@@ tb/tb_stepper_phase_sequencer.sv @@
`timescale 1ns / 1ps

module tb_stepper_phase_sequencer;
  import sps_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NOP = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SEGMENT_ITEMS = 140;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  int mismatches;
  int outstanding;
  int checked;
  int sent_count;
  int send_idle;
  int recv_idle;
  int hold_left;
  int cycle_count;
  int mode_writes;

  sps_cmd_if cmd_if ();
  sps_res_if res_if ();

  stepper_phase_sequencer dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sps_status_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd_if),
    .res         (res_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random back-pressure, or a long hold-off when requested.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_if.ready <= 1'b0;
        hold_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [ANGLE_W-1:0] deg);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.func <= f;
    cmd_if.angle_value <= deg;
    do @(posedge clk); while (!cmd_if.ready);
    sent_count++;
  endtask

  // Wait until every transaction has come back, then let the pipeline settle.
  task automatic drain();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_step_mode(input logic half);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_STEP_MODE, 2'b00};
    pwdata <= {31'd0, half};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mode_writes++;
  endtask

  initial begin
    int r;
    int ticks;
    int seg_end;
    logic [FUNC_W-1:0] f;
    logic [ANGLE_W-1:0] deg;

    rst = 1'b1;
    cmd_if.valid = 1'b0;
    cmd_if.func = FUNC_TICK;
    cmd_if.angle_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sent_count = 0;
    hold_left = 0;
    cycle_count = 0;
    mode_writes = 0;
    send_idle = 36;
    recv_idle = 67;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed checks
    write_step_mode(1'b1);
    send_cmd(FUNC_TICK, '0);                // tick while not running
    send_cmd(FUNC_NOP, 9'h1FF);             // unused code reports status
    send_cmd(FUNC_SET_CURRENT, 9'd360);
    send_cmd(FUNC_SET_CURRENT, 9'd361);     // above range, ignored
    send_cmd(FUNC_SET_TARGET, 9'h1FF);      // ignored, not busy
    send_cmd(FUNC_SET_TARGET, 9'd360);      // already there
    send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_MOVE_RIGHT, 9'd361);      // direction and zero still applied
    send_cmd(FUNC_MOVE_LEFT, 9'd0);
    send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_HOME, '0);
    repeat (4) send_cmd(FUNC_TICK, '0);
    send_cmd(FUNC_STOP, '0);
    send_cmd(FUNC_TICK, '0);                // stop de-energizes here
    send_cmd(FUNC_MOVE_RIGHT, 9'd1);
    repeat (4) send_cmd(FUNC_TICK, '0);
    drain();
    write_step_mode(1'b0);                  // switch to full step mid-move
    repeat (4) send_cmd(FUNC_TICK, '0);

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle = 36; recv_idle = 67; end
        1: begin send_idle = 67; recv_idle = 36; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (int h = 0; h < 2; h++) begin
        drain();
        write_step_mode(h[0] ^ p[0]);
        // long output stall while commands keep coming
        if (h == 0) hold_left = HOLD_CYCLES;
        seg_end = sent_count + SEGMENT_ITEMS;
        while (sent_count < seg_end) begin
          r = $urandom_range(99);
          if (r < 10) begin
            f = FUNC_W'($urandom_range(7));
            deg = ANGLE_W'($urandom_range(511));
          end else if (r < 18) begin
            f = FUNC_SET_CURRENT;
            deg = ANGLE_W'($urandom_range(511));
          end else if (r < 26) begin
            f = FUNC_SET_TARGET;
            deg = ANGLE_W'($urandom_range(511));
          end else if (r < 31) begin
            f = FUNC_HOME;
            deg = ANGLE_W'($urandom_range(511));
          end else if (r < 38) begin
            f = FUNC_STOP;
            deg = ANGLE_W'($urandom_range(511));
          end else begin
            f = $urandom_range(1) ? FUNC_MOVE_LEFT : FUNC_MOVE_RIGHT;
            deg = ($urandom_range(9) == 0) ? ANGLE_W'($urandom_range(511))
                                           : ANGLE_W'($urandom_range(3));
          end
          send_cmd(f, deg);
          ticks = $urandom_range(40);
          repeat (ticks) send_cmd(FUNC_TICK, ANGLE_W'($urandom_range(511)));
        end
      end
    end

    drain();
    repeat (10) @(negedge clk);
    $display("Sent %0d commands across %0d step-mode writes and three idle profiles",
             sent_count, mode_writes);
    $display("Compared %0d status results, with three long output stalls", checked);
    if (mismatches == 0 && outstanding == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

@@ sim.f @@
design/sps_pkg.sv
design/sps_cmd_if.sv
design/sps_res_if.sv
design/sps_cfg.sv
design/sps_core.sv
design/sps_conv.sv
design/stepper_phase_sequencer.sv
tb/sps_status_checker.sv
tb/tb_stepper_phase_sequencer.sv
